@@ hdl/dehf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dehf_pkg: shared types for the duplicate event history filter
// Event record layout and the token link passed along the cell chain.
// ---------------------------------------------------------------------------
package dehf_pkg;

    localparam int unsigned DeviceW = 64;
    localparam int unsigned MoveW   = 32;
    localparam int unsigned FlagW   = 16;

    localparam logic KindCheck = 1'b0;
    localparam logic KindClear = 1'b1;

    // One pointer event as stored in a history entry
    typedef struct packed {
        logic        [DeviceW-1:0] device_id;
        logic signed [MoveW-1:0]   move_x;
        logic signed [MoveW-1:0]   move_y;
        logic        [FlagW-1:0]   motion_flags;
        logic        [FlagW-1:0]   btn_flags;
        logic        [FlagW-1:0]   btn_word;
    } t_event;

    // Search token moving one cell per cycle, with the hit seen so far
    typedef struct packed {
        logic tok;
        logic hit;
    } t_link;

endpackage

@@ hdl/dehf_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dehf_cell: one history entry of the filter chain
// Holds one event, compares it with the broadcast event when the search
// token passes, and takes its neighbor's entry when the chain shifts.
// ---------------------------------------------------------------------------
module dehf_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dehf_pkg::t_event i_event,
    input  dehf_pkg::t_event i_prev_entry,
    input  dehf_pkg::t_link  i_link,
    input  logic            i_shift,
    input  logic            i_clear,
    output dehf_pkg::t_event o_entry,
    output dehf_pkg::t_link  o_link
);

    dehf_pkg::t_event r_entry;
    dehf_pkg::t_event n_entry;
    dehf_pkg::t_link  r_link;
    dehf_pkg::t_link  n_link;

    always_comb begin
        n_entry = r_entry;
        if (i_clear) begin
            n_entry = '0;
        end else if (i_shift) begin
            n_entry = i_prev_entry;
        end
    end

    // Pass the token on, folding in this entry's match
    always_comb begin
        n_link.tok = i_link.tok;
        n_link.hit = i_link.tok & (i_link.hit | (r_entry == i_event));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_link  <= '0;
        end else begin
            r_entry <= n_entry;
            r_link  <= n_link;
        end
    end

    assign o_entry = r_entry;
    assign o_link  = r_link;

endmodule

@@ hdl/duplicate_event_history_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// duplicate_event_history_filter: drop repeated pointer events
// Checks each event against a history of recent distinct events held in a
// chain of cells; records new events and reports repeats.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_ready  | i_kind, i_device_id,
//          |           |                          | i_move_x, i_move_y,
//          |           |                          | i_motion_flags,
//          |           |                          | i_btn_flags,
//          |           |                          | i_btn_word
//  out     | from block| o_out_valid / i_out_ready| o_is_repeat
//
// A check beat holds off the next acceptance until its search ends: the
// search token walks the cell chain one cell per cycle, and the record
// update happens at the same edge that returns the block to idle.
// A clear beat completes at its accept edge: every cell zeroes there.
// Reset zeroes every entry, which is the cleared history.
// A stalled result holds in the output register; the next beat is taken
// when the block is idle and that register is empty or being drained in the same cycle.
// ---------------------------------------------------------------------------
module duplicate_event_history_filter #(
    parameter int unsigned HISTORY_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [dehf_pkg::DeviceW-1:0]   i_device_id,
    input  logic signed [dehf_pkg::MoveW-1:0] i_move_x,
    input  logic signed [dehf_pkg::MoveW-1:0] i_move_y,
    input  logic [dehf_pkg::FlagW-1:0]     i_motion_flags,
    input  logic [dehf_pkg::FlagW-1:0]     i_btn_flags,
    input  logic [dehf_pkg::FlagW-1:0]     i_btn_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_is_repeat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             r_state;
    logic             n_state;
    logic             r_start;
    logic             n_start;
    dehf_pkg::t_event r_event;
    dehf_pkg::t_event n_event;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_repeat;
    logic             n_out_repeat;

    logic             w_accept;
    logic             w_clear;
    logic             w_done;
    logic             w_hit;
    logic             w_shift;

    dehf_pkg::t_event w_entry [HISTORY_DEPTH];
    dehf_pkg::t_link  w_link  [HISTORY_DEPTH];
    logic [HISTORY_DEPTH:0] w_tokens;

    // Take a beat only when idle and the result register will be free
    assign o_in_ready = (r_state == ST_IDLE) & (~r_out_valid | i_out_ready);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_clear    = w_accept & (i_kind == dehf_pkg::KindClear);

    // The token leaving the last cell ends the search
    assign w_done  = w_link[HISTORY_DEPTH-1].tok;
    assign w_hit   = w_link[HISTORY_DEPTH-1].hit;
    // New event: shift the chain, cell 0 takes the event, the oldest drops out.
    // The history is a set, so this matches overwriting at a round-robin slot.
    assign w_shift = w_done & ~w_hit;

    genvar g;
    generate
        for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
            dehf_pkg::t_event w_prev;
            dehf_pkg::t_link  w_lin;
            if (g == 0) begin : g_head
                assign w_prev = r_event;
                assign w_lin  = '{tok: r_start, hit: 1'b0};
            end else begin : g_body
                assign w_prev = w_entry[g-1];
                assign w_lin  = w_link[g-1];
            end
            dehf_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_event      (r_event),
                .i_prev_entry (w_prev),
                .i_link       (w_lin),
                .i_shift      (w_shift),
                .i_clear      (w_clear),
                .o_entry      (w_entry[g]),
                .o_link       (w_link[g])
            );
            assign w_tokens[g+1] = w_link[g].tok;
        end
    endgenerate
    assign w_tokens[0] = r_start;

    always_comb begin
        n_state      = r_state;
        n_start      = 1'b0;
        n_event      = r_event;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_repeat = r_out_repeat;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_event.device_id    = i_device_id;
                    n_event.move_x       = i_move_x;
                    n_event.move_y       = i_move_y;
                    n_event.motion_flags = i_motion_flags;
                    n_event.btn_flags    = i_btn_flags;
                    n_event.btn_word     = i_btn_word;
                    if (w_clear) begin
                        // Clear answers at once with not-a-repeat
                        n_out_valid  = 1'b1;
                        n_out_repeat = 1'b0;
                    end else begin
                        // Launch the search token into cell 0
                        n_start = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_done) begin
                    n_out_valid  = 1'b1;
                    n_out_repeat = w_hit;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_event      <= n_event;
        r_out_repeat <= n_out_repeat;
    end

    assign o_out_valid = r_out_valid;
    assign o_is_repeat = r_out_repeat;

    // At most one search token is ever in flight
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tokens))
        else $error("more than one search token in the chain");

    // A token reaches the chain end only during a search
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_SCAN))
        else $error("search finished outside the scan state");

    // A check beat starts a search on the next cycle
    a_check_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == dehf_pkg::KindCheck) |=> (r_start && r_state == ST_SCAN))
        else $error("check beat did not launch a search");

    // A clear beat answers not-a-repeat on the next cycle
    a_clear_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_out_valid && !r_out_repeat && r_state == ST_IDLE))
        else $error("clear beat did not produce a not-repeat result");

    // No result appears while the search is still under way
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !w_done) |=> (r_state == ST_IDLE || !r_out_valid))
        else $error("result raised before the search ended");

endmodule

@@ test/dehf_repeat_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dehf_repeat_checker: repeat-flag predictor and compare for the filter
// Keeps its own copy of the event history, predicts is_repeat for every
// accepted input beat, and compares each output beat in order.
// ---------------------------------------------------------------------------
module dehf_repeat_checker #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_kind,
    input  logic [dehf_pkg::DeviceW-1:0]      i_device_id,
    input  logic signed [dehf_pkg::MoveW-1:0] i_move_x,
    input  logic signed [dehf_pkg::MoveW-1:0] i_move_y,
    input  logic [dehf_pkg::FlagW-1:0]        i_motion_flags,
    input  logic [dehf_pkg::FlagW-1:0]        i_btn_flags,
    input  logic [dehf_pkg::FlagW-1:0]        i_btn_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_is_repeat,
    output int                                o_fail_count,
    output int                                o_pending
);

    dehf_pkg::t_event seen_events [DEPTH];
    int unsigned      next_slot;
    logic             repeat_flags_due [$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    // Zero every entry and the insert slot
    function automatic void forget_history();
        for (int i = 0; i < DEPTH; i++) begin
            seen_events[i] = '0;
        end
        next_slot = 0;
    endfunction

    // Look the event up; record it at the insert slot when it is new
    function automatic logic lookup_and_record(input logic kind,
                                               input dehf_pkg::t_event ev);
        logic found;
        found = 1'b0;
        if (kind == dehf_pkg::KindClear) begin
            forget_history();
            return 1'b0;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (seen_events[i] == ev) begin
                found = 1'b1;
            end
        end
        if (!found) begin
            seen_events[next_slot] = ev;
            next_slot = (next_slot + 1) % DEPTH;
        end
        return found;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        dehf_pkg::t_event ev;
        logic             want;
        if (!i_rst_n) begin
            forget_history();
            repeat_flags_due.delete();
        end else begin
            // drain first: a result at this edge belongs to an older beat
            if (i_out_valid && i_out_ready) begin
                if (repeat_flags_due.size() == 0) begin
                    note_failure($sformatf("unexpected result is_repeat=%b", i_is_repeat));
                end else begin
                    want = repeat_flags_due.pop_front();
                    if (i_is_repeat !== want) begin
                        note_failure($sformatf("is_repeat expected %b actual %b",
                                               want, i_is_repeat));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                ev.device_id    = i_device_id;
                ev.move_x       = i_move_x;
                ev.move_y       = i_move_y;
                ev.motion_flags = i_motion_flags;
                ev.btn_flags    = i_btn_flags;
                ev.btn_word     = i_btn_word;
                want = lookup_and_record(i_kind, ev);
                repeat_flags_due.insert(repeat_flags_due.size(), want);
            end
        end
        o_pending <= repeat_flags_due.size();
    end

endmodule

@@ test/tb_duplicate_event_history_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_duplicate_event_history_filter: stimulus and verdict for the filter
// Drives directed corner events, then random well-formed event streams
// (repeats, near misses, fresh events, clears) with random idling on both
// channels; a side checker predicts every is_repeat flag and compares.
// ---------------------------------------------------------------------------
module tb_duplicate_event_history_filter;

    localparam int unsigned HistDepth  = 8;
    localparam int          RandBeats  = 750;
    localparam int          TailBeats  = 100;   // last beats run with no idling
    localparam int          PauseAt    = 300;   // sender drains the block here
    localparam int          HoldAfter  = 120;   // results before the long stall
    localparam int          HoldCycles = 300;
    localparam int          CycleLimit = 200000;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic                   i_kind         = dehf_pkg::KindCheck;
    logic [dehf_pkg::DeviceW-1:0]     i_device_id    = '0;
    logic signed [dehf_pkg::MoveW-1:0] i_move_x      = '0;
    logic signed [dehf_pkg::MoveW-1:0] i_move_y      = '0;
    logic [dehf_pkg::FlagW-1:0]       i_motion_flags = '0;
    logic [dehf_pkg::FlagW-1:0]       i_btn_flags    = '0;
    logic [dehf_pkg::FlagW-1:0]       i_btn_word     = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic                   o_is_repeat;

    int  fail_count;
    int  pending;
    int  results_seen   = 0;
    int  cycle_count    = 0;
    bit  quiet_tail     = 1'b0;
    bit  long_hold_done = 1'b0;

    dehf_pkg::t_event recent_events [$];   // pool of recently sent events for repeats

    always #5 i_clk = ~i_clk;

    duplicate_event_history_filter #(
        .HISTORY_DEPTH (HistDepth)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_device_id    (i_device_id),
        .i_move_x       (i_move_x),
        .i_move_y       (i_move_y),
        .i_motion_flags (i_motion_flags),
        .i_btn_flags    (i_btn_flags),
        .i_btn_word     (i_btn_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_is_repeat    (o_is_repeat)
    );

    dehf_repeat_checker #(
        .DEPTH (HistDepth)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_device_id    (i_device_id),
        .i_move_x       (i_move_x),
        .i_move_y       (i_move_y),
        .i_motion_flags (i_motion_flags),
        .i_btn_flags    (i_btn_flags),
        .i_btn_word     (i_btn_word),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_is_repeat    (o_is_repeat),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Count cycles; stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Count drained results so the receiver knows when to start its long stall
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // Pick a value of the given width, biased toward zero, all ones and MSB only
    function automatic logic [63:0] pick_word(input int bits);
        logic [63:0] mask;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return mask;
            2:       return 64'd1 << (bits - 1);
            default: return {$urandom, $urandom} & mask;
        endcase
    endfunction

    function automatic dehf_pkg::t_event fresh_event();
        dehf_pkg::t_event ev;
        logic [63:0]      word;
        ev.device_id    = pick_word(dehf_pkg::DeviceW);
        word            = pick_word(dehf_pkg::MoveW);
        ev.move_x       = word[dehf_pkg::MoveW-1:0];
        word            = pick_word(dehf_pkg::MoveW);
        ev.move_y       = word[dehf_pkg::MoveW-1:0];
        word            = pick_word(dehf_pkg::FlagW);
        ev.motion_flags = word[dehf_pkg::FlagW-1:0];
        word            = pick_word(dehf_pkg::FlagW);
        ev.btn_flags    = word[dehf_pkg::FlagW-1:0];
        word            = pick_word(dehf_pkg::FlagW);
        ev.btn_word     = word[dehf_pkg::FlagW-1:0];
        return ev;
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic send_beat(input logic kind, input dehf_pkg::t_event ev);
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_device_id    <= ev.device_id;
        i_move_x       <= ev.move_x;
        i_move_y       <= ev.move_y;
        i_motion_flags <= ev.motion_flags;
        i_btn_flags    <= ev.btn_flags;
        i_btn_word     <= ev.btn_word;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == dehf_pkg::KindCheck) begin
            recent_events.insert(recent_events.size(), ev);
            if (recent_events.size() > 12) begin
                void'(recent_events.pop_front());
            end
        end
    endtask

    task automatic hold_idle(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted flag has been drained
    task automatic drain_block();
        hold_idle(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (!quiet_tail && $urandom_range(3, 0) == 0) begin
            hold_idle($urandom_range(11, 1));
        end
    endtask

    // Receiver: random ready bursts, one long stall, no stalls in the tail
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && results_seen >= HoldAfter) begin
                i_out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if (quiet_tail || $urandom_range(2, 0) != 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(20, 1)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge i_clk);
            end
        end
    end

    // Sender: directed corners, then random event streams, then verdict
    initial begin
        dehf_pkg::t_event zero_ev;
        dehf_pkg::t_event ones_ev;
        dehf_pkg::t_event edge_ev;
        dehf_pkg::t_event third_ev;
        dehf_pkg::t_event ev;
        int               pick;

        zero_ev = '0;
        ones_ev = '1;
        edge_ev = '0;
        edge_ev.move_x = 32'sh8000_0000;
        edge_ev.move_y = 32'sh7FFF_FFFF;
        third_ev = fresh_event();
        third_ev.device_id = 64'h0123_4567_89AB_CDEF;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero event matches the reset history
        send_beat(dehf_pkg::KindCheck, zero_ev);
        send_beat(dehf_pkg::KindCheck, ones_ev);
        send_beat(dehf_pkg::KindCheck, ones_ev);
        maybe_gap();
        send_beat(dehf_pkg::KindCheck, edge_ev);
        // near misses: one bit off in each field in turn
        ev = ones_ev; ev.device_id[63]    = 1'b0; send_beat(dehf_pkg::KindCheck, ev);
        ev = ones_ev; ev.move_x[31]       = 1'b0; send_beat(dehf_pkg::KindCheck, ev);
        ev = ones_ev; ev.move_y[0]        = 1'b0; send_beat(dehf_pkg::KindCheck, ev);
        ev = ones_ev; ev.motion_flags[15] = 1'b0; send_beat(dehf_pkg::KindCheck, ev);
        ev = ones_ev; ev.btn_flags[0]     = 1'b0; send_beat(dehf_pkg::KindCheck, ev);
        ev = ones_ev; ev.btn_word[7]      = 1'b0; send_beat(dehf_pkg::KindCheck, ev);
        // history now full; wrap overwrites the oldest entries
        send_beat(dehf_pkg::KindCheck, third_ev);
        send_beat(dehf_pkg::KindCheck, ones_ev);
        send_beat(dehf_pkg::KindCheck, edge_ev);
        send_beat(dehf_pkg::KindCheck, third_ev);
        // no zero entry left, so the zero event is new, then a repeat
        send_beat(dehf_pkg::KindCheck, zero_ev);
        send_beat(dehf_pkg::KindCheck, zero_ev);
        maybe_gap();
        // clear ignores its payload
        send_beat(dehf_pkg::KindClear, fresh_event());
        send_beat(dehf_pkg::KindCheck, third_ev);
        send_beat(dehf_pkg::KindCheck, zero_ev);
        send_beat(dehf_pkg::KindClear, ones_ev);
        send_beat(dehf_pkg::KindClear, zero_ev);
        send_beat(dehf_pkg::KindCheck, third_ev);

        for (int n = 0; n < RandBeats; n++) begin
            if (n == RandBeats - TailBeats) begin
                quiet_tail = 1'b1;
            end
            if (n == PauseAt) begin
                drain_block();
            end
            maybe_gap();
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
                send_beat(dehf_pkg::KindClear, fresh_event());
            end else if (pick < 50 && recent_events.size() > 0) begin
                send_beat(dehf_pkg::KindCheck,
                          recent_events[$urandom_range(recent_events.size() - 1, 0)]);
            end else if (pick < 65 && recent_events.size() > 0) begin
                // flip one bit somewhere in a recent event
                ev = recent_events[$urandom_range(recent_events.size() - 1, 0)];
                ev = ev ^ (dehf_pkg::t_event'(1)
                           << $urandom_range($bits(dehf_pkg::t_event) - 1, 0));
                send_beat(dehf_pkg::KindCheck, ev);
            end else if (pick < 72) begin
                send_beat(dehf_pkg::KindCheck, zero_ev);
            end else begin
                send_beat(dehf_pkg::KindCheck, fresh_event());
            end
        end

        drain_block();
        repeat (HistDepth + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
